/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the PID controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define PIDIP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PIDIP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pidip_pkg.sv */
// Types and constants shared by the PID controller modules.
package pidip_pkg;

  // Register indexes of the configuration port.
  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_MODE      = 3'd0;
  localparam cfg_idx_t REG_TARGET    = 3'd1;
  localparam cfg_idx_t REG_KP        = 3'd2;
  localparam cfg_idx_t REG_KI        = 3'd3;
  localparam cfg_idx_t REG_KD        = 3'd4;
  localparam cfg_idx_t REG_OUT_SCALE = 3'd5;
  localparam cfg_idx_t REG_OUT_MAX   = 3'd6;
  localparam cfg_idx_t REG_OUT_MIN   = 3'd7;

  // Controller modes.
  localparam logic MODE_INC = 1'b0;
  localparam logic MODE_POS = 1'b1;

  // Datapath widths.
  localparam int unsigned CfgW   = 16;
  localparam int unsigned ChunkW = 24;
  localparam int unsigned TermW  = 48;
  localparam int unsigned MulBW  = 25;
  localparam int unsigned ProdW  = 41;
  localparam int unsigned AccW   = 64;

  // Register file contents.
  typedef struct packed {
    logic               mode;
    logic signed [15:0] target;
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic signed [15:0] out_scale;
    logic signed [15:0] out_max;
    logic signed [15:0] out_min;
  } cfg_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;       // update the accumulator
    logic load;     // start from the base value instead of the accumulator
    logic hi_half;  // product belongs to the upper operand chunk
  } mac_ctl_t;

endpackage

/* sv/pid_controller_inc_pos_top.sv */
// PID controller, incremental or positional, with a saturated drive output.
// One measured sample is taken per transfer on the input channel and one drive
// value with its limit flag leaves on the output channel. An item passes
// through these steps before the next input transfer is taken: the error
// differences and error sum, eight passes through the single shared 16 x 25
// multiply-accumulate unit (three gain terms in two operand chunks each, then
// the output scale in two chunks), the upper clamp, and the lower clamp with
// the output load. A result may be stalled while the next item is being worked
// on; a stall that lasts past the end of that work delays the next output load.
// Configuration writes are taken at any time but are meant to happen only
// while the block is idle.
module pid_controller_inc_pos_top import pidip_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_actual,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_drive,
  output logic               out_at_limit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [CfgW-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_MUL, ST_CLAMP, ST_DONE} state_t;

  cfg_t                     cfg;
  state_t                   state_r;
  logic [2:0]               step_r;

  logic signed [16:0]       err_now_r;
  logic signed [16:0]       err_prev_r;
  logic signed [16:0]       err_prev2_r;
  logic signed [31:0]       err_sum_r;
  logic signed [TermW-1:0]  out_acc_r;
  logic signed [17:0]       dp_r;
  logic signed [18:0]       dd_r;
  logic signed [TermW-1:0]  term_r;
  logic signed [AccW-1:0]   clamp_r;
  logic                     hit_r;
  logic                     out_valid_r;
  logic signed [15:0]       out_drive_r;
  logic                     out_at_limit_r;

  logic signed [16:0]       err_in;
  logic signed [17:0]       dp_c;
  logic signed [18:0]       dd_c;
  logic signed [32:0]       sum_c;
  logic signed [31:0]       sum_sat;
  logic signed [TermW-1:0]  sel_val;
  logic signed [15:0]       op_a;
  logic signed [MulBW-1:0]  op_b;
  logic signed [AccW-1:0]   mac_base;
  logic signed [AccW-1:0]   acc;
  mac_ctl_t                 mac_ctl;
  logic signed [AccW-1:0]   lim_hi;
  logic signed [AccW-1:0]   lim_lo;
  logic                     below_lo;
  logic signed [AccW-1:0]   final_val;
  logic                     out_free;

  pidip_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pidip_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .base (mac_base),
    .acc  (acc)
  );

  // Error of the incoming sample and the differences of the error history.
  assign err_in = {cfg.target[15], cfg.target} - {in_actual[15], in_actual};
  assign dp_c   = {err_now_r[16], err_now_r} - {err_prev_r[16], err_prev_r};
  assign dd_c   = {{2{err_now_r[16]}}, err_now_r}
                - ({{2{err_prev_r[16]}}, err_prev_r} <<< 1)
                + {{2{err_prev2_r[16]}}, err_prev2_r};

  // Error sum with saturation at the 32-bit limits.
  assign sum_c = {err_sum_r[31], err_sum_r} + {{16{err_now_r[16]}}, err_now_r};
  always_comb begin
    if (sum_c[32] != sum_c[31]) begin
      sum_sat = sum_c[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_c[31:0];
    end
  end

  // Operand selection for each pass of the multiply-accumulate unit.
  always_comb begin
    unique case (step_r[2:1])
      2'd0: begin
        op_a    = cfg.kp;
        sel_val = (cfg.mode == MODE_POS) ? {{31{err_now_r[16]}}, err_now_r}
                                         : {{30{dp_r[17]}}, dp_r};
      end
      2'd1: begin
        op_a    = cfg.ki;
        sel_val = (cfg.mode == MODE_POS) ? {{16{err_sum_r[31]}}, err_sum_r}
                                         : {{31{err_now_r[16]}}, err_now_r};
      end
      2'd2: begin
        op_a    = cfg.kd;
        sel_val = (cfg.mode == MODE_POS) ? {{30{dp_r[17]}}, dp_r}
                                         : {{29{dd_r[18]}}, dd_r};
      end
      default: begin
        op_a    = cfg.out_scale;
        sel_val = step_r[0] ? term_r : acc[TermW-1:0];
      end
    endcase
  end

  // Lower chunk enters unsigned, upper chunk carries the sign.
  assign op_b = step_r[0] ? {sel_val[TermW-1], sel_val[TermW-1:ChunkW]}
                          : {1'b0, sel_val[ChunkW-1:0]};

  // The scale pass starts from the kept accumulator in incremental mode.
  assign mac_base = (step_r == 3'd6 && cfg.mode == MODE_INC)
                  ? {{(AccW-TermW){out_acc_r[TermW-1]}}, out_acc_r}
                  : '0;

  assign mac_ctl.en      = (state_r == ST_MUL);
  assign mac_ctl.load    = (step_r == 3'd0) || (step_r == 3'd6);
  assign mac_ctl.hi_half = step_r[0];

  // Clamp window in the accumulator's signed 64-bit Q48.16 format (48 integer bits including the sign).
  assign lim_hi    = {{32{cfg.out_max[15]}}, cfg.out_max, 16'h0000};
  assign lim_lo    = {{32{cfg.out_min[15]}}, cfg.out_min, 16'h0000};
  assign below_lo  = clamp_r < lim_lo;
  assign final_val = below_lo ? lim_lo : clamp_r;
  assign out_free  = !out_valid_r || !out_stall;

  // Sequencer, state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      step_r         <= 3'd0;
      err_now_r      <= '0;
      err_prev_r     <= '0;
      err_prev2_r    <= '0;
      err_sum_r      <= '0;
      out_acc_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // A finished item in ST_DONE takes over the output register instead.
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            err_prev2_r <= err_prev_r;
            err_prev_r  <= err_now_r;
            err_now_r   <= err_in;
            state_r     <= ST_PREP;
          end
        end
        ST_PREP: begin
          dp_r <= dp_c;
          dd_r <= dd_c;
          if (cfg.mode == MODE_POS) begin
            err_sum_r <= sum_sat;
          end
          step_r  <= 3'd0;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          if (step_r == 3'd6) begin
            term_r <= acc[TermW-1:0];
          end
          step_r <= step_r + 3'd1;
          if (step_r == 3'd7) begin
            state_r <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if (acc > lim_hi) begin
            clamp_r <= lim_hi;
            hit_r   <= 1'b1;
          end else begin
            clamp_r <= acc;
            hit_r   <= 1'b0;
          end
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_acc_r      <= final_val[TermW-1:0];
            out_drive_r    <= final_val[31:16];
            out_at_limit_r <= hit_r || below_lo;
            out_valid_r    <= 1'b1;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_drive    = out_drive_r;
  assign out_at_limit = out_at_limit_r;

endmodule

/* sv/pidip_regs.sv */
// Configuration register file of the PID controller.
module pidip_regs import pidip_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [CfgW-1:0] cfg_wdata,
  output cfg_t            cfg
);

  cfg_t cfg_r;

  // Register writes; the mode register keeps only the lowest data bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_INC;
      cfg_r.target    <= 16'sd0;
      cfg_r.kp        <= 16'sd0;
      cfg_r.ki        <= 16'sd0;
      cfg_r.kd        <= 16'sd0;
      cfg_r.out_scale <= 16'sd256;
      cfg_r.out_max   <= 16'sh7FFF;
      cfg_r.out_min   <= 16'sh8000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MODE:      cfg_r.mode      <= cfg_wdata[0];
        REG_TARGET:    cfg_r.target    <= cfg_wdata;
        REG_KP:        cfg_r.kp        <= cfg_wdata;
        REG_KI:        cfg_r.ki        <= cfg_wdata;
        REG_KD:        cfg_r.kd        <= cfg_wdata;
        REG_OUT_SCALE: cfg_r.out_scale <= cfg_wdata;
        REG_OUT_MAX:   cfg_r.out_max   <= cfg_wdata;
        REG_OUT_MIN:   cfg_r.out_min   <= cfg_wdata;
        default:       cfg_r.mode      <= cfg_r.mode;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/pidip_mac.sv */
// Shared 16 x 25 signed multiply-accumulate unit with a 64-bit accumulator.
module pidip_mac import pidip_pkg::*; (
  input  logic                   clk,
  input  mac_ctl_t               ctl,
  input  logic signed [15:0]     op_a,
  input  logic signed [MulBW-1:0] op_b,
  input  logic signed [AccW-1:0] base,
  output logic signed [AccW-1:0] acc
);

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  prod_ext;
  logic signed [AccW-1:0]  addend;
  logic signed [AccW-1:0]  acc_nxt;
  logic signed [AccW-1:0]  acc_r;

  // Product, aligned to its operand chunk.
  assign prod     = op_a * op_b;
  assign prod_ext = {{(AccW-ProdW){prod[ProdW-1]}}, prod};
  assign addend   = ctl.hi_half ? (prod_ext <<< ChunkW) : prod_ext;

  // Accumulate onto the running sum or onto a fresh base value.
  assign acc_nxt = (ctl.load ? base : acc_r) + addend;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

/* sv/pidip_checker.sv */
// Port-level assertions of the PID controller and their binding to the top level.
`include "assert_macros.svh"

module pidip_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_drive,
  input logic               out_at_limit
);

  // An input transfer makes the block busy in the next cycle.
  `PIDIP_ASSERT_CLK(a_busy_after_in, clk, rst_n, (in_valid && !in_stall |=> in_stall), "input transfer did not start work")

  // A new result appears only together with the return to idle.
  `PIDIP_ASSERT_CLK(a_result_at_idle, clk, rst_n, ($rose(out_valid) |-> !in_stall), "result shown while still busy")

  // The end of the busy period always leaves a result behind.
  `PIDIP_ASSERT_CLK(a_idle_has_result, clk, rst_n, ($fell(in_stall) && $past(rst_n) |-> out_valid), "work ended without a result")

  // A stalled result holds its value.
  `PIDIP_ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && out_stall |=> out_valid && $stable(out_drive) && $stable(out_at_limit)), "stalled result changed")

  // Reset leaves the block idle with no result pending.
  `PIDIP_ASSERT_ALWAYS(a_reset_idle, clk, (!rst_n |=> !out_valid && !in_stall), "reset did not clear the block")

endmodule

bind pid_controller_inc_pos_top pidip_checker u_pidip_checker (.*);
